// ===== rtl/tccw_pkg.sv =====
// tccw_pkg: constants, types and the control store of the text console writer
// microprogram step addresses, datapath operations and jump conditions
// used by text_console_char_writer; no dependencies

package tccw_pkg;

   // screen geometry
   localparam int COLUMNS      = 80;
   localparam int SCREEN_CELLS = 2000;

   // fixed field widths
   localparam int CODE_W = 16;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int ATTR_W = 8;

   // derived widths
   localparam int ADDR_W = $clog2(SCREEN_CELLS);
   localparam int CUR_W  = $clog2(SCREEN_CELLS + COLUMNS);
   localparam int COL_W  = $clog2(COLUMNS);

   // sweep limits
   localparam int SWEEP_LAST = SCREEN_CELLS - 1;
   localparam int COPY_LAST  = SCREEN_CELLS - COLUMNS - 1;

   // character codes and cell values
   localparam logic [7:0]        CH_BS       = 8'h08;
   localparam logic [7:0]        CH_TAB      = 8'h09;
   localparam logic [7:0]        CH_LF       = 8'h0A;
   localparam logic [7:0]        CH_CR       = 8'h0D;
   localparam logic [7:0]        CH_SPACE    = 8'h20;
   localparam logic [CODE_W-1:0] BLANK_CELL  = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

   // action codes
   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam int PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_TAKE,
      OP_PUT,
      OP_BACK,
      OP_DOWN,
      OP_HOME,
      OP_TAB_PUT,
      OP_SCR_FIRST,
      OP_SCR_COPY,
      OP_FILL,
      OP_SCR_UP,
      OP_RESPOND,
      OP_READ
   } op_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NOT_SWEEP_END,
      C_NO_BEAT,
      C_IS_READ,
      C_IS_BS,
      C_IS_LF,
      C_IS_CR,
      C_IS_TAB,
      C_NO_SCROLL,
      C_NOT_COPY_END,
      C_TAB_MORE,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // step addresses
   localparam pc_type P_CLEAR    = 5'd0;
   localparam pc_type P_IDLE     = 5'd1;
   localparam pc_type P_DEC_READ = 5'd2;
   localparam pc_type P_DEC_BS   = 5'd3;
   localparam pc_type P_DEC_LF   = 5'd4;
   localparam pc_type P_DEC_CR   = 5'd5;
   localparam pc_type P_DEC_TAB  = 5'd6;
   localparam pc_type P_PUT      = 5'd7;
   localparam pc_type P_BACK     = 5'd8;
   localparam pc_type P_DOWN     = 5'd9;
   localparam pc_type P_HOME     = 5'd10;
   localparam pc_type P_TAB      = 5'd11;
   localparam pc_type P_CHECK    = 5'd12;
   localparam pc_type P_SCR_RD   = 5'd13;
   localparam pc_type P_SCR_CP   = 5'd14;
   localparam pc_type P_SCR_FILL = 5'd15;
   localparam pc_type P_SCR_UP   = 5'd16;
   localparam pc_type P_AFTER    = 5'd17;
   localparam pc_type P_FINISH   = 5'd18;
   localparam pc_type P_RETURN   = 5'd19;
   localparam pc_type P_READ     = 5'd20;

   // control store: taken jump goes to target, otherwise to the next step
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: P_IDLE};
      case (pc)
         P_CLEAR:    w = '{op: OP_CLEAR,     cond: C_NOT_SWEEP_END, target: P_CLEAR};
         P_IDLE:     w = '{op: OP_TAKE,      cond: C_NO_BEAT,       target: P_IDLE};
         P_DEC_READ: w = '{op: OP_NOP,       cond: C_IS_READ,       target: P_READ};
         P_DEC_BS:   w = '{op: OP_NOP,       cond: C_IS_BS,         target: P_BACK};
         P_DEC_LF:   w = '{op: OP_NOP,       cond: C_IS_LF,         target: P_DOWN};
         P_DEC_CR:   w = '{op: OP_NOP,       cond: C_IS_CR,         target: P_HOME};
         P_DEC_TAB:  w = '{op: OP_NOP,       cond: C_IS_TAB,        target: P_TAB};
         P_PUT:      w = '{op: OP_PUT,       cond: C_ALWAYS,        target: P_CHECK};
         P_BACK:     w = '{op: OP_BACK,      cond: C_ALWAYS,        target: P_CHECK};
         P_DOWN:     w = '{op: OP_DOWN,      cond: C_ALWAYS,        target: P_CHECK};
         P_HOME:     w = '{op: OP_HOME,      cond: C_ALWAYS,        target: P_CHECK};
         P_TAB:      w = '{op: OP_TAB_PUT,   cond: C_ALWAYS,        target: P_CHECK};
         P_CHECK:    w = '{op: OP_NOP,       cond: C_NO_SCROLL,     target: P_AFTER};
         P_SCR_RD:   w = '{op: OP_SCR_FIRST, cond: C_ALWAYS,        target: P_SCR_CP};
         P_SCR_CP:   w = '{op: OP_SCR_COPY,  cond: C_NOT_COPY_END,  target: P_SCR_CP};
         P_SCR_FILL: w = '{op: OP_FILL,      cond: C_NOT_SWEEP_END, target: P_SCR_FILL};
         P_SCR_UP:   w = '{op: OP_SCR_UP,    cond: C_ALWAYS,        target: P_AFTER};
         P_AFTER:    w = '{op: OP_NOP,       cond: C_TAB_MORE,      target: P_TAB};
         P_FINISH:   w = '{op: OP_RESPOND,   cond: C_RSP_BUSY,      target: P_FINISH};
         P_RETURN:   w = '{op: OP_NOP,       cond: C_ALWAYS,        target: P_IDLE};
         P_READ:     w = '{op: OP_READ,      cond: C_ALWAYS,        target: P_FINISH};
         default:    w = '{op: OP_NOP,       cond: C_ALWAYS,        target: P_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/tccw_ram.sv =====
// tccw_ram: generic simple dual-port ram, one write and one read port
// read data is registered and holds while no read is issued
// no dependencies

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_char_writer.sv =====
// text_console_char_writer: text screen store with a linear cursor, run by a microprogram
// depends on tccw_pkg and tccw_ram
// a scroll does its row copy and blank fill through the single screen ram, one cell per cycle
// one item at a time: a new request is taken only while the writer is idle
// reset: synchronous; a clearing pass zeroes the screen, requests stall

module text_console_char_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [tccw_pkg::CODE_W-1:0]   req_char_code,
   input  logic [tccw_pkg::IDX_W-1:0]    req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccw_pkg::POS_W-1:0]    rsp_cursor_position,
   output logic [tccw_pkg::CODE_W-1:0]   rsp_cell_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_default_attribute
);

   import tccw_pkg::*;

   pc_type              pc_ff, pc_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [1:0]          tab_cnt_ff, tab_cnt_in;
   logic [ATTR_W-1:0]   attr_ff;
   logic                act_ff, act_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                idx_ok_ff, idx_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [CODE_W-1:0]   rsp_value_ff, rsp_value_in;

   ctrl_word_type       cw;
   logic                jump;
   logic                rsp_busy;
   logic                col_last;
   logic                col_first;
   logic                sweep_end;
   logic                copy_end;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CODE_W-1:0]   wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CODE_W-1:0]   rd_data;

   tccw_ram #(
      .WIDTH (CODE_W),
      .DEPTH (SCREEN_CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cw        = ucode_rom(pc_ff);
   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign col_last  = (col_ff == COL_W'(COLUMNS - 1));
   assign col_first = (col_ff == '0);
   assign sweep_end = (addr_ff == ADDR_W'(SWEEP_LAST));
   assign copy_end  = (addr_ff == ADDR_W'(COPY_LAST));

   assign req_stall = (pc_ff != P_IDLE);
   assign csr_ready = 1'b1;

   // jump condition
   always_comb begin
      unique case (cw.cond)
         C_ALWAYS:        jump = 1'b1;
         C_NOT_SWEEP_END: jump = !sweep_end;
         C_NO_BEAT:       jump = !req_valid;
         C_IS_READ:       jump = (act_ff == ACT_READ);
         C_IS_BS:         jump = (code_ff[7:0] == CH_BS);
         C_IS_LF:         jump = (code_ff[7:0] == CH_LF);
         C_IS_CR:         jump = (code_ff[7:0] == CH_CR);
         C_IS_TAB:        jump = (code_ff[7:0] == CH_TAB);
         C_NO_SCROLL:     jump = (cur_ff < CUR_W'(SCREEN_CELLS));
         C_NOT_COPY_END:  jump = !copy_end;
         C_TAB_MORE:      jump = (code_ff[7:0] == CH_TAB) && (tab_cnt_ff != '0);
         C_RSP_BUSY:      jump = rsp_busy;
         default:         jump = 1'b1;
      endcase
   end

   assign pc_in = jump ? cw.target : pc_type'(pc_ff + 1'b1);

   // datapath driven by the control word
   always_comb begin
      addr_in      = addr_ff;
      cur_in       = cur_ff;
      col_in       = col_ff;
      tab_cnt_in   = tab_cnt_ff;
      act_in       = act_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(cur_ff);
      wr_data      = code_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      unique case (cw.op)
         OP_NOP: begin
         end
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
            addr_in = sweep_end ? '0 : ADDR_W'(addr_ff + 1'b1);
         end
         OP_TAKE: begin
            if (req_valid) begin
               act_in     = req_action;
               code_in    = req_char_code;
               // a zero attribute byte takes the default attribute
               if (req_char_code[15:8] == '0) begin
                  code_in[15:8] = attr_ff;
               end
               idx_in     = ADDR_W'(req_cell_index);
               idx_ok_in  = (32'(req_cell_index) < 32'(SCREEN_CELLS));
               tab_cnt_in = '0;
            end
         end
         OP_PUT: begin
            wr_en  = 1'b1;
            cur_in = CUR_W'(cur_ff + 1'b1);
            col_in = col_last ? '0 : COL_W'(col_ff + 1'b1);
         end
         OP_BACK: begin
            if (cur_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(cur_ff - 1'b1);
               wr_data = {code_ff[15:8], CH_SPACE};
               cur_in  = CUR_W'(cur_ff - 1'b1);
               col_in  = col_first ? COL_W'(COLUMNS - 1) : COL_W'(col_ff - 1'b1);
            end
         end
         OP_DOWN: begin
            cur_in = CUR_W'(cur_ff + CUR_W'(COLUMNS));
         end
         OP_HOME: begin
            cur_in = CUR_W'(cur_ff - CUR_W'(col_ff));
            col_in = '0;
         end
         OP_TAB_PUT: begin
            wr_en      = 1'b1;
            wr_data    = {attr_ff, CH_SPACE};
            cur_in     = CUR_W'(cur_ff + 1'b1);
            col_in     = col_last ? '0 : COL_W'(col_ff + 1'b1);
            tab_cnt_in = 2'(tab_cnt_ff + 1'b1);
         end
         OP_SCR_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(addr_ff + ADDR_W'(COLUMNS));
         end
         OP_SCR_COPY: begin
            // write the cell read last step, fetch the one for the next
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = rd_data;
            rd_en   = !copy_end;
            rd_addr = ADDR_W'(addr_ff + ADDR_W'(COLUMNS) + 1'b1);
            addr_in = ADDR_W'(addr_ff + 1'b1);
         end
         OP_FILL: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = BLANK_CELL;
            addr_in = sweep_end ? '0 : ADDR_W'(addr_ff + 1'b1);
         end
         OP_SCR_UP: begin
            cur_in = CUR_W'(cur_ff - CUR_W'(COLUMNS));
         end
         OP_RESPOND: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(cur_ff);
               rsp_value_in = (act_ff == ACT_READ && idx_ok_ff) ? rd_data : '0;
            end
         end
         OP_READ: begin
            rd_en   = idx_ok_ff;
            rd_addr = idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_CLEAR;
         addr_ff      <= '0;
         cur_ff       <= '0;
         col_ff       <= '0;
         tab_cnt_ff   <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         addr_ff      <= addr_in;
         cur_ff       <= cur_in;
         col_ff       <= col_in;
         tab_cnt_ff   <= tab_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_default_attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      code_ff      <= code_in;
      idx_ff       <= idx_in;
      idx_ok_ff    <= idx_ok_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_value      = rsp_value_ff;

endmodule
